@@ sv/ttl_pkg.sv @@
package ttl_pkg;

   typedef enum logic [1:0] {
      MODE_TICK        = 2'd0,
      MODE_ADD_SLEEPER = 2'd1,
      MODE_ADD_LISTEN  = 2'd2,
      MODE_REMOVE      = 2'd3
   } mode_type;

   localparam logic [2:0] KIND_FIRED    = 3'd0;
   localparam logic [2:0] KIND_WOKEN    = 3'd1;
   localparam logic [2:0] KIND_SCHEDULE = 3'd2;
   localparam logic [2:0] KIND_ACCEPTED = 3'd3;
   localparam logic [2:0] KIND_FULL     = 3'd4;
   localparam logic [2:0] KIND_MISSING  = 3'd5;

   localparam int unsigned CountWidth = 64;
   localparam int unsigned IvalWidth  = 31;
   localparam logic [IvalWidth-1:0] ElapsedMax = {IvalWidth{1'b1}};

   typedef struct packed {
      logic [1:0]  mode;
      logic [7:0]  pid;
      logic [30:0] interval;
      logic [7:0]  listener_id;
   } req_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] listener_id_res;
      logic [7:0] pid_res;
      logic       last;
   } rsp_type;

   typedef struct packed {
      logic start;
      logic busy;
      logic done;
      logic zero;
   } div_ctl_type;

endpackage

@@ sv/tick_timer_listener_and_sleep_table.sv @@
// Channel | Direction | Payload
// req_    | in        | ttl_pkg::req_type (mode, pid, interval, listener_id)
// rsp_    | out       | ttl_pkg::rsp_type (kind, listener_id_res, pid_res, last)
// A tick runs each listener with a nonzero period through the serial remainder unit,
// skips the unit on a zero period and reports each listener that fires, then checks each
// sleeper slot, reports each wake, and closes with the schedule point.
// Adds answer in the next cycle; a remove finds the listener, then shifts the rest down.
// Reset is synchronous and clears the counts and the tick count; tables are not cleared.
// A stalled response holds the sequencer; no new request is taken until the last one leaves.
module tick_timer_listener_and_sleep_table #(
   parameter int unsigned LISTENER_SLOTS = 16,
   parameter int unsigned SLEEPER_SLOTS  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttl_pkg::rsp_type rsp_data
);
   localparam int unsigned LIdx = (LISTENER_SLOTS > 1) ? $clog2(LISTENER_SLOTS) : 1;
   localparam int unsigned SIdx = (SLEEPER_SLOTS > 1) ? $clog2(SLEEPER_SLOTS) : 1;
   localparam int unsigned LCnt = $clog2(LISTENER_SLOTS + 1);
   localparam int unsigned SCnt = $clog2(SLEEPER_SLOTS + 1);

   typedef enum logic [3:0] {
      S_IDLE, S_L_READ, S_L_DIV, S_L_WAIT, S_S_READ, S_S_CHECK, S_S_MOVE,
      S_RM_SCAN, S_RM_SHIFT, S_EMIT
   } state_type;

   // listener and sleeper tables
   logic [7:0]                   lid_mem [LISTENER_SLOTS];
   logic [ttl_pkg::IvalWidth-1:0] lper_mem [LISTENER_SLOTS];
   logic [7:0]                   spid_mem [SLEEPER_SLOTS];
   logic [ttl_pkg::IvalWidth-1:0] star_mem [SLEEPER_SLOTS];
   logic [ttl_pkg::IvalWidth-1:0] sela_mem [SLEEPER_SLOTS];

   state_type                     state_ff;
   logic [ttl_pkg::CountWidth-1:0] tick_ff;
   logic [LCnt-1:0]               lcount_ff;
   logic [SCnt-1:0]               scount_ff;
   logic [LCnt-1:0]               li_ff;
   logic [SCnt-1:0]               si_ff;
   ttl_pkg::req_type              req_ff;
   logic                          rsp_valid_ff;
   ttl_pkg::rsp_type              rsp_ff;
   ttl_pkg::rsp_type              pend_ff; // result waiting for the output register
   logic                          resume_ff; // set to go on at next_ff after a result, not idle
   state_type                     next_ff;
   logic [7:0]                    rd_lid_ff;
   logic [ttl_pkg::IvalWidth-1:0] rd_lper_ff;
   logic [7:0]                    rd_spid_ff;
   logic [ttl_pkg::IvalWidth-1:0] rd_star_ff;
   logic [ttl_pkg::IvalWidth-1:0] rd_sela_ff;
   logic [7:0]                    mv_spid_ff;
   logic [ttl_pkg::IvalWidth-1:0] mv_star_ff;
   logic [ttl_pkg::IvalWidth-1:0] mv_sela_ff;

   logic                 div_start;
   ttl_pkg::div_ctl_type div_status;
   logic [ttl_pkg::IvalWidth-1:0] aged;

   ttl_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tick_ff),
      .divisor  (rd_lper_ff),
      .status   (div_status)
   );

   assign req_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign div_start = (state_ff == S_L_DIV);
   assign aged = (rd_sela_ff != ttl_pkg::ElapsedMax) ? rd_sela_ff + 1'b1 : rd_sela_ff;

   always_ff @(posedge clock) begin
      if (state_ff == S_L_READ) begin
         rd_lid_ff  <= lid_mem[li_ff[LIdx-1:0]];
         rd_lper_ff <= lper_mem[li_ff[LIdx-1:0]];
      end
      if (state_ff == S_RM_SCAN) begin
         rd_lid_ff  <= lid_mem[li_ff[LIdx-1:0]];
      end
      if (state_ff == S_S_READ) begin
         rd_spid_ff <= spid_mem[si_ff[SIdx-1:0]];
         rd_star_ff <= star_mem[si_ff[SIdx-1:0]];
         rd_sela_ff <= sela_mem[si_ff[SIdx-1:0]];
         mv_spid_ff <= spid_mem[SIdx'(scount_ff - 1'b1)];
         mv_star_ff <= star_mem[SIdx'(scount_ff - 1'b1)];
         mv_sela_ff <= sela_mem[SIdx'(scount_ff - 1'b1)];
      end
      if (state_ff == S_IDLE && req_valid && req_ready) begin
         if (req_data.mode == ttl_pkg::MODE_ADD_SLEEPER && scount_ff < SCnt'(SLEEPER_SLOTS)) begin
            spid_mem[SIdx'(scount_ff)] <= req_data.pid;
            star_mem[SIdx'(scount_ff)] <= req_data.interval;
            sela_mem[SIdx'(scount_ff)] <= '0;
         end
         if (req_data.mode == ttl_pkg::MODE_ADD_LISTEN && lcount_ff < LCnt'(LISTENER_SLOTS)) begin
            lid_mem[LIdx'(lcount_ff)]  <= req_data.listener_id;
            lper_mem[LIdx'(lcount_ff)] <= req_data.interval;
         end
      end
      if (state_ff == S_RM_SHIFT && (resume_ff || rd_lid_ff == req_ff.listener_id)
          && li_ff + 1'b1 < lcount_ff) begin
         lid_mem[li_ff[LIdx-1:0]]  <= lid_mem[LIdx'(li_ff + 1'b1)];
         lper_mem[li_ff[LIdx-1:0]] <= lper_mem[LIdx'(li_ff + 1'b1)];
      end
      if (state_ff == S_S_CHECK) begin
         sela_mem[si_ff[SIdx-1:0]] <= aged;
      end
      if (state_ff == S_S_MOVE) begin
         spid_mem[si_ff[SIdx-1:0]] <= mv_spid_ff;
         star_mem[si_ff[SIdx-1:0]] <= mv_star_ff;
         sela_mem[si_ff[SIdx-1:0]] <= mv_sela_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         tick_ff      <= '0;
         lcount_ff    <= '0;
         scount_ff    <= '0;
         li_ff        <= '0;
         si_ff        <= '0;
         rsp_valid_ff <= 1'b0;
         resume_ff    <= 1'b0;
         next_ff      <= S_IDLE;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid && req_ready) begin
                  req_ff <= req_data;
                  li_ff  <= '0;
                  si_ff  <= '0;
                  unique case (req_data.mode)
                     ttl_pkg::MODE_TICK: begin
                        tick_ff  <= tick_ff + 1'b1;
                        state_ff <= S_L_READ;
                     end
                     ttl_pkg::MODE_ADD_SLEEPER: begin
                        rsp_ff <= '{kind: (scount_ff < SCnt'(SLEEPER_SLOTS)) ?
                           ttl_pkg::KIND_ACCEPTED : ttl_pkg::KIND_FULL,
                           listener_id_res: 8'd0, pid_res: 8'd0, last: 1'b1};
                        if (scount_ff < SCnt'(SLEEPER_SLOTS)) scount_ff <= scount_ff + 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end
                     ttl_pkg::MODE_ADD_LISTEN: begin
                        rsp_ff <= '{kind: (lcount_ff < LCnt'(LISTENER_SLOTS)) ?
                           ttl_pkg::KIND_ACCEPTED : ttl_pkg::KIND_FULL,
                           listener_id_res: 8'd0, pid_res: 8'd0, last: 1'b1};
                        if (lcount_ff < LCnt'(LISTENER_SLOTS)) lcount_ff <= lcount_ff + 1'b1;
                        rsp_valid_ff <= 1'b1;
                     end
                     ttl_pkg::MODE_REMOVE: begin
                        state_ff <= S_RM_SCAN;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_L_READ: begin
               if (li_ff < lcount_ff) begin
                  state_ff <= S_L_DIV;
               end else begin
                  state_ff <= S_S_READ;
               end
            end
            S_L_DIV: begin
               if (rd_lper_ff == '0) begin
                  li_ff    <= li_ff + 1'b1;
                  state_ff <= S_L_READ;
               end else begin
                  state_ff <= S_L_WAIT;
               end
            end
            S_L_WAIT: begin
               if (div_status.done) begin
                  li_ff <= li_ff + 1'b1;
                  if (div_status.zero) begin
                     pend_ff   <= '{kind: ttl_pkg::KIND_FIRED, listener_id_res: rd_lid_ff,
                                    pid_res: 8'd0, last: 1'b0};
                     resume_ff <= 1'b1;
                     next_ff   <= S_L_READ;
                     state_ff  <= S_EMIT;
                  end else begin
                     state_ff <= S_L_READ;
                  end
               end
            end
            S_S_READ: begin
               if (si_ff < scount_ff) begin
                  state_ff <= S_S_CHECK;
               end else begin
                  pend_ff   <= '{kind: ttl_pkg::KIND_SCHEDULE, listener_id_res: 8'd0,
                                 pid_res: 8'd0, last: 1'b1};
                  resume_ff <= 1'b0;
                  state_ff  <= S_EMIT;
               end
            end
            S_S_CHECK: begin
               if (aged == rd_star_ff) begin
                  pend_ff   <= '{kind: ttl_pkg::KIND_WOKEN, listener_id_res: 8'd0,
                                 pid_res: rd_spid_ff, last: 1'b0};
                  state_ff  <= S_S_MOVE;
               end else begin
                  si_ff    <= si_ff + 1'b1;
                  state_ff <= S_S_READ;
               end
            end
            S_S_MOVE: begin
               scount_ff <= scount_ff - 1'b1;
               resume_ff <= 1'b1;
               next_ff   <= S_S_READ;
               state_ff  <= S_EMIT;
            end
            S_RM_SCAN: begin
               if (li_ff >= lcount_ff) begin
                  rsp_ff       <= '{kind: ttl_pkg::KIND_MISSING, listener_id_res: 8'd0,
                                    pid_res: 8'd0, last: 1'b1};
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= S_IDLE;
               end else begin
                  state_ff <= S_RM_SHIFT;
               end
            end
            S_RM_SHIFT: begin
               // First pass compares; once matched, the rest of the list shifts down.
               if (resume_ff || rd_lid_ff == req_ff.listener_id) begin
                  if (li_ff + 1'b1 < lcount_ff) begin
                     resume_ff <= 1'b1;
                     li_ff     <= li_ff + 1'b1;
                     state_ff  <= S_RM_SHIFT;
                  end else begin
                     lcount_ff    <= lcount_ff - 1'b1;
                     resume_ff    <= 1'b0;
                     rsp_ff       <= '{kind: ttl_pkg::KIND_ACCEPTED, listener_id_res: 8'd0,
                                       pid_res: 8'd0, last: 1'b1};
                     rsp_valid_ff <= 1'b1;
                     state_ff     <= S_IDLE;
                  end
               end else begin
                  li_ff    <= li_ff + 1'b1;
                  state_ff <= S_RM_SCAN;
               end
            end
            S_EMIT: begin
               if (!rsp_valid_ff) begin
                  rsp_ff       <= pend_ff;
                  rsp_valid_ff <= 1'b1;
                  resume_ff    <= 1'b0;
                  state_ff     <= resume_ff ? next_ff : S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule

@@ sv/ttl_divider.sv @@
// Restoring remainder unit: one dividend bit per cycle.
module ttl_divider (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic [ttl_pkg::CountWidth-1:0]      dividend,
   input  logic [ttl_pkg::IvalWidth-1:0]       divisor,
   output ttl_pkg::div_ctl_type                status
);
   localparam int unsigned StepWidth = $clog2(ttl_pkg::CountWidth);

   logic [ttl_pkg::CountWidth-1:0] shift_ff, shift_in;
   logic [ttl_pkg::IvalWidth:0]    rem_ff, rem_in;
   logic [ttl_pkg::IvalWidth-1:0]  dsr_ff, dsr_in;
   logic [StepWidth-1:0]           step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [ttl_pkg::IvalWidth+1:0]  trial;
   logic [ttl_pkg::IvalWidth+1:0]  diff;

   always_comb begin
      shift_in = shift_ff;
      rem_in   = rem_ff;
      dsr_in   = dsr_ff;
      step_in  = step_ff;
      busy_in  = busy_ff;
      done_in  = 1'b0;
      trial    = {rem_ff, shift_ff[ttl_pkg::CountWidth-1]};
      diff     = trial - {2'b00, dsr_ff};
      if (start) begin
         shift_in = dividend;
         rem_in   = '0;
         dsr_in   = divisor;
         step_in  = '0;
         busy_in  = 1'b1;
      end else if (busy_ff) begin
         shift_in = {shift_ff[ttl_pkg::CountWidth-2:0], 1'b0};
         if (!diff[ttl_pkg::IvalWidth+1]) begin
            rem_in = diff[ttl_pkg::IvalWidth:0];
         end else begin
            rem_in = trial[ttl_pkg::IvalWidth:0];
         end
         step_in = step_ff + 1'b1;
         if (step_ff == StepWidth'(ttl_pkg::CountWidth - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      dsr_ff   <= dsr_in;
   end

   assign status.start = start;
   assign status.busy  = busy_ff;
   assign status.done  = done_ff;
   assign status.zero  = (rem_ff == '0);
endmodule

@@ sv/ttl_checker.sv @@
module ttl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input ttl_pkg::rsp_type rsp_data
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response waits");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("ready again right after a request");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.kind <= ttl_pkg::KIND_MISSING)
      else $error("response kind out of range");

   a_single_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.kind == ttl_pkg::KIND_ACCEPTED ||
                    rsp_data.kind == ttl_pkg::KIND_FULL ||
                    rsp_data.kind == ttl_pkg::KIND_MISSING ||
                    rsp_data.kind == ttl_pkg::KIND_SCHEDULE) |-> rsp_data.last)
      else $error("final response without last");
endmodule

bind tick_timer_listener_and_sleep_table ttl_checker u_ttl_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
